### rtl/dwlm_pkg.sv
// Shared widths, constants and pipeline payload types for the dual white LED drive mixer.
`timescale 1ns / 1ps
package dwlm_pkg;

  localparam int KELVIN_W    = 16;
  localparam int LIGHT_W     = 23;
  localparam int LEVEL_W     = 16;
  localparam int EFF_W       = 16;
  localparam int SHARE_W     = 11;
  localparam int TERM_W      = 27;
  localparam int PROD_W      = 50;
  localparam int NUM_W       = 64;
  localparam int DEN_W       = 48;
  localparam int DIVIDEND_W  = 65;
  localparam int DIVISOR_W   = 49;
  localparam int QUOT_W      = 17;
  localparam int DZ_SHIFT    = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  localparam logic [KELVIN_W-1:0] T_WARM     = 16'd3000;
  localparam logic [KELVIN_W-1:0] T_COOL     = 16'd5000;
  localparam logic [SHARE_W-1:0]  SPAN       = 11'd2000;
  localparam logic [LIGHT_W-1:0]  L_MAX      = 23'd6553600;
  localparam logic [LEVEL_W-1:0]  DEADZONE   = 16'd256;
  localparam logic [NUM_W-1:0]    SCALE_NUM  = 64'd13107;
  localparam logic [DEN_W-1:0]    SCALE_DEN  = 48'd1310720;

  localparam logic [EFF_W-1:0] WARM_EFF_RESET = 16'd17695;
  localparam logic [EFF_W-1:0] COOL_EFF_RESET = 16'd16384;

  localparam logic [CFG_IDX_W-1:0] REG_WARM_EFF = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOL_EFF = 8'd1;

  typedef struct packed {
    logic lz;
    logic ez;
    logic w_nz;
    logic w_dz;
    logic c_nz;
    logic c_dz;
  } flags_t;

  typedef struct packed {
    logic [DIVIDEND_W-1:0] m_w;
    logic [DIVIDEND_W-1:0] m_c;
    logic [DIVISOR_W-1:0]  dv;
    flags_t                flg;
  } div_in_t;

  typedef struct packed {
    logic [QUOT_W-1:0] q_w;
    logic [QUOT_W-1:0] q_c;
    flags_t            flg;
  } div_out_t;

endpackage

### rtl/dwlm_front.sv
// Five-stage front end: shares, efficacy terms, lightness products and rounding dividends.
`timescale 1ns / 1ps
module dwlm_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  logic [dwlm_pkg::KELVIN_W-1:0]      up_kelvin,
  input  logic [dwlm_pkg::LIGHT_W-1:0]       up_light,
  input  logic [dwlm_pkg::EFF_W-1:0]         warm_eff,
  input  logic [dwlm_pkg::EFF_W-1:0]         cool_eff,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output dwlm_pkg::div_in_t                  dn_data
);

  logic [4:0] v_r;
  logic [4:0] en;

  logic [dwlm_pkg::SHARE_W-1:0] wn_nxt;
  logic [dwlm_pkg::SHARE_W-1:0] cn_nxt;
  logic [dwlm_pkg::LIGHT_W-1:0] l_nxt;

  logic [dwlm_pkg::SHARE_W-1:0] s0_wn_r;
  logic [dwlm_pkg::SHARE_W-1:0] s0_cn_r;
  logic [dwlm_pkg::LIGHT_W-1:0] s0_l_r;
  logic                         s0_lz_r;

  logic [dwlm_pkg::TERM_W-1:0]  s1_wt_r;
  logic [dwlm_pkg::TERM_W-1:0]  s1_ct_r;
  logic [dwlm_pkg::LIGHT_W-1:0] s1_l_r;
  logic                         s1_lz_r;

  logic [dwlm_pkg::TERM_W-1:0]  s2_comb_r;
  logic [dwlm_pkg::PROD_W-1:0]  s2_pw_r;
  logic [dwlm_pkg::PROD_W-1:0]  s2_pc_r;
  logic                         s2_lz_r;

  logic [dwlm_pkg::NUM_W-1:0]   s3_nw_r;
  logic [dwlm_pkg::NUM_W-1:0]   s3_nc_r;
  logic [dwlm_pkg::DEN_W-1:0]   s3_d_r;
  logic                         s3_ez_r;
  logic                         s3_lz_r;

  dwlm_pkg::div_in_t            s4_r;
  dwlm_pkg::div_in_t            s4_nxt;
  logic [dwlm_pkg::NUM_W-1:0]   dz_lim;

  assign en[4]    = !v_r[4] || dn_ready;
  assign en[3]    = !v_r[3] || en[4];
  assign en[2]    = !v_r[2] || en[3];
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[4];
  assign dn_data  = s4_r;

  always_comb begin
    l_nxt = (up_light > dwlm_pkg::L_MAX) ? dwlm_pkg::L_MAX : up_light;
    if (up_kelvin <= dwlm_pkg::T_WARM) begin
      wn_nxt = dwlm_pkg::SPAN;
    end else if (up_kelvin >= dwlm_pkg::T_COOL) begin
      wn_nxt = '0;
    end else begin
      wn_nxt = dwlm_pkg::SHARE_W'(dwlm_pkg::T_COOL - up_kelvin);
    end
    cn_nxt = dwlm_pkg::SPAN - wn_nxt;
  end

  always_comb begin
    dz_lim         = dwlm_pkg::NUM_W'({s3_d_r, {dwlm_pkg::DZ_SHIFT{1'b0}}});
    s4_nxt.m_w     = {s3_nw_r, 1'b0} + dwlm_pkg::DIVIDEND_W'(s3_d_r);
    s4_nxt.m_c     = {s3_nc_r, 1'b0} + dwlm_pkg::DIVIDEND_W'(s3_d_r);
    s4_nxt.dv      = {s3_d_r, 1'b0};
    s4_nxt.flg.lz  = s3_lz_r;
    s4_nxt.flg.ez  = s3_ez_r;
    s4_nxt.flg.w_nz = (s3_nw_r != '0);
    s4_nxt.flg.w_dz = (s3_nw_r < dz_lim);
    s4_nxt.flg.c_nz = (s3_nc_r != '0);
    s4_nxt.flg.c_dz = (s3_nc_r < dz_lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_wn_r <= wn_nxt;
      s0_cn_r <= cn_nxt;
      s0_l_r  <= l_nxt;
      s0_lz_r <= (up_light == '0);
    end
    if (en[1]) begin
      s1_wt_r <= dwlm_pkg::TERM_W'(s0_wn_r) * dwlm_pkg::TERM_W'(warm_eff);
      s1_ct_r <= dwlm_pkg::TERM_W'(s0_cn_r) * dwlm_pkg::TERM_W'(cool_eff);
      s1_l_r  <= s0_l_r;
      s1_lz_r <= s0_lz_r;
    end
    if (en[2]) begin
      s2_comb_r <= s1_wt_r + s1_ct_r;
      s2_pw_r   <= dwlm_pkg::PROD_W'(s1_wt_r) * dwlm_pkg::PROD_W'(s1_l_r);
      s2_pc_r   <= dwlm_pkg::PROD_W'(s1_ct_r) * dwlm_pkg::PROD_W'(s1_l_r);
      s2_lz_r   <= s1_lz_r;
    end
    if (en[3]) begin
      s3_nw_r <= dwlm_pkg::NUM_W'(s2_pw_r) * dwlm_pkg::SCALE_NUM;
      s3_nc_r <= dwlm_pkg::NUM_W'(s2_pc_r) * dwlm_pkg::SCALE_NUM;
      s3_d_r  <= dwlm_pkg::DEN_W'(s2_comb_r) * dwlm_pkg::SCALE_DEN;
      s3_ez_r <= (s2_comb_r == '0);
      s3_lz_r <= s2_lz_r;
    end
    if (en[4]) begin
      s4_r <= s4_nxt;
    end
  end

endmodule

### rtl/dwlm_div.sv
// Pipelined restoring divider, one quotient bit per stage, for both drive channels.
`timescale 1ns / 1ps
module dwlm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  dwlm_pkg::div_in_t  up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output dwlm_pkg::div_out_t dn_data
);

  localparam int NS = dwlm_pkg::QUOT_W;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;
  logic [NS-1:0] v_in;

  logic [dwlm_pkg::DIVIDEND_W-1:0] rem_w_r [NS];
  logic [dwlm_pkg::DIVIDEND_W-1:0] rem_c_r [NS];
  logic [dwlm_pkg::DIVISOR_W-1:0]  dv_r    [NS];
  logic [dwlm_pkg::QUOT_W-1:0]     q_w_r   [NS];
  logic [dwlm_pkg::QUOT_W-1:0]     q_c_r   [NS];
  dwlm_pkg::flags_t                flg_r   [NS];

  logic [dwlm_pkg::DIVIDEND_W-1:0] rw_in   [NS];
  logic [dwlm_pkg::DIVIDEND_W-1:0] rc_in   [NS];
  logic [dwlm_pkg::DIVISOR_W-1:0]  dv_in   [NS];
  logic [dwlm_pkg::QUOT_W-1:0]     qw_in   [NS];
  logic [dwlm_pkg::QUOT_W-1:0]     qc_in   [NS];
  dwlm_pkg::flags_t                flg_in  [NS];

  logic [dwlm_pkg::DIVIDEND_W-1:0] sh      [NS];
  logic [dwlm_pkg::DIVIDEND_W-1:0] rem_w_nxt [NS];
  logic [dwlm_pkg::DIVIDEND_W-1:0] rem_c_nxt [NS];
  logic [dwlm_pkg::QUOT_W-1:0]     q_w_nxt [NS];
  logic [dwlm_pkg::QUOT_W-1:0]     q_c_nxt [NS];
  logic [NS-1:0]                   ge_w;
  logic [NS-1:0]                   ge_c;

  always_comb begin
    en[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready      = en[0];
  assign dn_valid      = v_r[NS-1];
  assign dn_data.q_w   = q_w_r[NS-1];
  assign dn_data.q_c   = q_c_r[NS-1];
  assign dn_data.flg   = flg_r[NS-1];

  always_comb begin
    v_in[0]   = up_valid;
    rw_in[0]  = up_data.m_w;
    rc_in[0]  = up_data.m_c;
    dv_in[0]  = up_data.dv;
    qw_in[0]  = '0;
    qc_in[0]  = '0;
    flg_in[0] = up_data.flg;
    for (int k = 1; k < NS; k++) begin
      v_in[k]   = v_r[k-1];
      rw_in[k]  = rem_w_r[k-1];
      rc_in[k]  = rem_c_r[k-1];
      dv_in[k]  = dv_r[k-1];
      qw_in[k]  = q_w_r[k-1];
      qc_in[k]  = q_c_r[k-1];
      flg_in[k] = flg_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      sh[k]        = dwlm_pkg::DIVIDEND_W'(dv_in[k]) << (NS - 1 - k);
      ge_w[k]      = (rw_in[k] >= sh[k]);
      ge_c[k]      = (rc_in[k] >= sh[k]);
      rem_w_nxt[k] = ge_w[k] ? (rw_in[k] - sh[k]) : rw_in[k];
      rem_c_nxt[k] = ge_c[k] ? (rc_in[k] - sh[k]) : rc_in[k];
      q_w_nxt[k]   = {qw_in[k][dwlm_pkg::QUOT_W-2:0], ge_w[k]};
      q_c_nxt[k]   = {qc_in[k][dwlm_pkg::QUOT_W-2:0], ge_c[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        rem_w_r[k] <= rem_w_nxt[k];
        rem_c_r[k] <= rem_c_nxt[k];
        dv_r[k]    <= dv_in[k];
        q_w_r[k]   <= q_w_nxt[k];
        q_c_r[k]   <= q_c_nxt[k];
        flg_r[k]   <= flg_in[k];
      end
    end
  end

endmodule

### rtl/dual_white_led_drive_mixer.sv
// Top level of the dual white LED drive mixer: configuration registers and output stage.
`timescale 1ns / 1ps
// Each input beat carries a colour temperature in kelvin and a lightness percentage
// in Q7.16; each output beat carries the warm and cool LED drive levels and a status
// bit that is set when the combined efficacy is zero and the lightness is not zero.
// One output beat is produced for every input beat, in order.
// The configuration channel writes the warm efficacy (index 0) and the cool efficacy
// (index 1), both unsigned Q2.14; writes to other indices are ignored, and writes are
// always taken. Configuration should only change while no beat is in flight.
// The block is a 23-stage pipeline: five front stages compute the shares, efficacy
// terms and scaled products, seventeen divider stages each resolve one quotient bit,
// and the last stage is the output register. One beat can be accepted every cycle
// while the output is not stalled by the receiver.
// Every stage has its own valid bit and advances when its successor can take data,
// so a stalled receiver only holds the stages that are full and bubbles still close up.
// Reset empties the pipeline and restores the efficacy registers to their defaults.
module dual_white_led_drive_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] color_temp_kelvin, [38:16] lightness_pct, [39] zero
  input  logic [dwlm_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] warm_level, [31:16] cool_level
  output logic [dwlm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] status
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dwlm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dwlm_pkg::EFF_W-1:0]          cfg_data
);

  logic [dwlm_pkg::EFF_W-1:0] warm_eff_r;
  logic [dwlm_pkg::EFF_W-1:0] cool_eff_r;

  logic               fr_valid;
  logic               fr_ready;
  dwlm_pkg::div_in_t  fr_data;
  logic               dv_valid;
  logic               dv_ready;
  dwlm_pkg::div_out_t dv_data;

  logic                             out_tvalid_r;
  logic [dwlm_pkg::LEVEL_W-1:0]     warm_r;
  logic [dwlm_pkg::LEVEL_W-1:0]     cool_r;
  logic                             status_r;
  logic [dwlm_pkg::LEVEL_W-1:0]     warm_nxt;
  logic [dwlm_pkg::LEVEL_W-1:0]     cool_nxt;
  logic                             status_nxt;
  logic                             out_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_eff_r <= dwlm_pkg::WARM_EFF_RESET;
      cool_eff_r <= dwlm_pkg::COOL_EFF_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dwlm_pkg::REG_WARM_EFF: warm_eff_r <= cfg_data;
        dwlm_pkg::REG_COOL_EFF: cool_eff_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dwlm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .up_kelvin (in_tdata[dwlm_pkg::KELVIN_W-1:0]),
    .up_light  (in_tdata[dwlm_pkg::KELVIN_W +: dwlm_pkg::LIGHT_W]),
    .warm_eff  (warm_eff_r),
    .cool_eff  (cool_eff_r),
    .dn_valid  (fr_valid),
    .dn_ready  (fr_ready),
    .dn_data   (fr_data)
  );

  dwlm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up_data  (fr_data),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .dn_data  (dv_data)
  );

  assign out_en   = !out_tvalid_r || out_tready;
  assign dv_ready = out_en;

  always_comb begin
    warm_nxt   = '0;
    cool_nxt   = '0;
    status_nxt = 1'b0;
    if (dv_data.flg.lz) begin
      status_nxt = 1'b0;
    end else if (dv_data.flg.ez) begin
      status_nxt = 1'b1;
    end else begin
      if (!dv_data.flg.w_nz) begin
        warm_nxt = '0;
      end else if (dv_data.flg.w_dz) begin
        warm_nxt = dwlm_pkg::DEADZONE;
      end else begin
        warm_nxt = dv_data.q_w[dwlm_pkg::LEVEL_W-1:0];
      end
      if (!dv_data.flg.c_nz) begin
        cool_nxt = '0;
      end else if (dv_data.flg.c_dz) begin
        cool_nxt = dwlm_pkg::DEADZONE;
      end else begin
        cool_nxt = dv_data.q_c[dwlm_pkg::LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_en) begin
      out_tvalid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      warm_r   <= warm_nxt;
      cool_r   <= cool_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {cool_r, warm_r};
  assign out_tuser  = status_r;

endmodule
